/* hw/rtl/fifo_segment_cache_defines.svh */
// fifo_segment_cache_defines.svh: assertion macros for the segment cache.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef FIFO_SEGMENT_CACHE_DEFINES_SVH
`define FIFO_SEGMENT_CACHE_DEFINES_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define FSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define FSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSC_ASSERT_SAME(label, ante, cons, msg)
`define FSC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hw/rtl/fsc_pkg.sv */
// fsc_pkg: shared types and fixed widths of the segment cache.
// No dependencies.
package fsc_pkg;

    localparam int OpW        = 2;
    localparam int IdW        = 32;
    localparam int BytesW     = 32;
    localparam int TargetW    = 12;
    localparam int MebiShift  = 20;
    localparam int TotalW     = 38;
    localparam int CounterW   = 64;
    localparam int CapW       = 7;
    localparam int CountOutW  = 7;
    localparam logic [CapW-1:0] CapReset = 7'd64;

    typedef enum logic [OpW-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TRIM   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // memory strobes from the engine
    typedef struct packed {
        logic wr_en;
        logic tag_rd_en;
        logic byte_rd_en;
    } t_mem_ctl;

endpackage

/* hw/rtl/fsc_if.sv */
// fsc_if: request, response and configuration channels of the segment cache.
// Depends on fsc_pkg.
interface fsc_req_if;
    import fsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OpW-1:0]       opcode;
    logic [IdW-1:0]       start_id;
    logic [IdW-1:0]       seg_count;
    logic [BytesW-1:0]    entry_bytes;
    logic [TargetW-1:0]   target_mb;
    modport source (output valid, opcode, start_id, seg_count, entry_bytes, target_mb,
                     input ready);
    modport sink   (input valid, opcode, start_id, seg_count, entry_bytes, target_mb,
                     output ready);
endinterface

interface fsc_rsp_if;
    import fsc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [TotalW-1:0]     evicted_bytes;
    logic [CountOutW-1:0]  entry_count;
    logic [TotalW-1:0]     total_bytes;
    logic [CounterW-1:0]   hit_count;
    logic [CounterW-1:0]   miss_count;
    modport source (output valid, hit, evicted_bytes, entry_count, total_bytes, hit_count,
                     miss_count, input ready);
    modport sink   (input valid, hit, evicted_bytes, entry_count, total_bytes, hit_count,
                     miss_count, output ready);
endinterface

interface fsc_cfg_if;
    import fsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CapW-1:0]  capacity;
    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

/* hw/rtl/fsc_mem.sv */
// fsc_mem: descriptor storage, a tag memory (start id, count) and a byte-size memory.
// One write port, one registered read port per memory. Depends on fsc_pkg.
module fsc_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  fsc_pkg::t_mem_ctl          i_ctl,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [fsc_pkg::IdW-1:0]    i_wr_start,
    input  logic [fsc_pkg::IdW-1:0]    i_wr_count,
    input  logic [fsc_pkg::BytesW-1:0] i_wr_bytes,
    input  logic [AW-1:0]              i_tag_rd_addr,
    input  logic [AW-1:0]              i_byte_rd_addr,
    output logic [fsc_pkg::IdW-1:0]    o_tag_start,
    output logic [fsc_pkg::IdW-1:0]    o_tag_count,
    output logic [fsc_pkg::BytesW-1:0] o_bytes
);
    import fsc_pkg::*;

    logic [2*IdW-1:0]  r_tag_mem  [DEPTH];
    logic [BytesW-1:0] r_byte_mem [DEPTH];
    logic [2*IdW-1:0]  r_tag_q;
    logic [BytesW-1:0] r_bytes_q;

    // tag memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_tag_mem[i_wr_addr] <= {i_wr_start, i_wr_count};
        end
        if (i_ctl.tag_rd_en) begin
            r_tag_q <= r_tag_mem[i_tag_rd_addr];
        end
    end

    // byte-size memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_byte_mem[i_wr_addr] <= i_wr_bytes;
        end
        if (i_ctl.byte_rd_en) begin
            r_bytes_q <= r_byte_mem[i_byte_rd_addr];
        end
    end

    assign o_tag_start = r_tag_q[2*IdW-1:IdW];
    assign o_tag_count = r_tag_q[IdW-1:0];
    assign o_bytes     = r_bytes_q;

endmodule

/* hw/rtl/fsc_engine.sv */
// fsc_engine: sequencer for lookup, insert and trim, status registers and the
// response register. Depends on fsc_pkg, fsc_if and the fsc_mem port set.
module fsc_engine #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int OW    = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fsc_pkg::CapW-1:0]   i_capacity,
    fsc_req_if.sink                    req,
    fsc_rsp_if.source                  rsp,
    output fsc_pkg::t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]              o_wr_addr,
    output logic [fsc_pkg::IdW-1:0]    o_wr_start,
    output logic [fsc_pkg::IdW-1:0]    o_wr_count,
    output logic [fsc_pkg::BytesW-1:0] o_wr_bytes,
    output logic [AW-1:0]              o_tag_rd_addr,
    output logic [AW-1:0]              o_byte_rd_addr,
    input  logic [fsc_pkg::IdW-1:0]    i_tag_start,
    input  logic [fsc_pkg::IdW-1:0]    i_tag_count,
    input  logic [fsc_pkg::BytesW-1:0] i_bytes
);
    import fsc_pkg::*;

    localparam int SW   = AW + 1;
    localparam int CMPW = (OW > CapW) ? OW : CapW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS_RD,
        S_INS_EV,
        S_INS_WR,
        S_TRIM,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [IdW-1:0]      r_sid;
    logic [IdW-1:0]      r_cnt;
    logic [BytesW-1:0]   r_eb;
    logic [TotalW-1:0]   r_target;
    logic [AW-1:0]       r_oldest;
    logic [OW-1:0]       r_occ;
    logic [TotalW-1:0]   r_total;
    logic [CounterW-1:0] r_hits;
    logic [CounterW-1:0] r_misses;
    logic [TotalW-1:0]   r_freed;
    logic                r_hit;
    logic [OW-1:0]       r_idx;
    logic                r_pend;
    logic [AW-1:0]       r_rd_ptr;
    logic                r_out_valid;
    logic                r_o_hit;
    logic [TotalW-1:0]   r_o_evicted;
    logic [CountOutW-1:0] r_o_count;
    logic [TotalW-1:0]   r_o_total;
    logic [CounterW-1:0] r_o_hits;
    logic [CounterW-1:0] r_o_misses;

    logic [SW-1:0]   scan_sum;
    logic [SW-1:0]   ins_sum;
    logic [AW-1:0]   scan_addr;
    logic [AW-1:0]   ins_addr;
    logic [AW-1:0]   oldest_inc;
    logic [AW-1:0]   ptr_inc;
    logic [CMPW-1:0] cap_ext;
    logic [CMPW-1:0] cap_eff;
    logic            evict;
    logic            scan_issue;
    logic            tag_match;
    logic            trim_more;
    logic            req_fire;
    logic            out_free;

    // circular slot arithmetic: offset from the oldest slot, wrapped once
    always_comb begin
        scan_sum  = {1'b0, r_oldest} + SW'(r_idx);
        ins_sum   = {1'b0, r_oldest} + SW'(r_occ);
        scan_addr = (scan_sum >= SW'(DEPTH)) ? AW'(scan_sum - SW'(DEPTH)) : AW'(scan_sum);
        ins_addr  = (ins_sum >= SW'(DEPTH)) ? AW'(ins_sum - SW'(DEPTH)) : AW'(ins_sum);
        oldest_inc = (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + AW'(1);
        ptr_inc    = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
    end

    // capacity clamped to 1..DEPTH
    always_comb begin
        cap_ext = CMPW'(i_capacity);
        if (cap_ext == '0) begin
            cap_eff = CMPW'(1);
        end else if (cap_ext > CMPW'(DEPTH)) begin
            cap_eff = CMPW'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
        evict = (CMPW'(r_occ) >= cap_eff);
    end

    assign scan_issue = (r_state == S_SCAN) && (r_idx < r_occ);
    assign tag_match  = (i_tag_start == r_sid) && (i_tag_count == r_cnt);
    assign trim_more  = (r_total > r_target) && (r_occ != '0);
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !r_out_valid || rsp.ready;

    // memory strobes; writes happen only in the last insert step, never
    // alongside a read, so no forwarding path is needed
    always_comb begin
        o_mem_ctl.wr_en      = (r_state == S_INS_WR);
        o_mem_ctl.tag_rd_en  = scan_issue;
        o_mem_ctl.byte_rd_en = (r_state == S_INS_RD) || (r_state == S_TRIM);
    end
    assign o_wr_addr      = ins_addr;
    assign o_wr_start     = r_sid;
    assign o_wr_count     = r_cnt;
    assign o_wr_bytes     = r_eb;
    assign o_tag_rd_addr  = scan_addr;
    assign o_byte_rd_addr = (r_state == S_TRIM) ? r_rd_ptr : r_oldest;

    assign req.ready         = (r_state == S_IDLE);
    assign rsp.valid         = r_out_valid;
    assign rsp.hit           = r_o_hit;
    assign rsp.evicted_bytes = r_o_evicted;
    assign rsp.entry_count   = r_o_count;
    assign rsp.total_bytes   = r_o_total;
    assign rsp.hit_count     = r_o_hits;
    assign rsp.miss_count    = r_o_misses;

    // sequencer, status and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_occ       <= '0;
            r_total     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // response valid: set on completion, cleared once taken
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (rsp.valid && rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_sid    <= req.start_id;
                        r_cnt    <= req.seg_count;
                        r_eb     <= req.entry_bytes;
                        r_target <= TotalW'({req.target_mb, {MebiShift{1'b0}}});
                        r_hit    <= 1'b0;
                        r_freed  <= '0;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_rd_ptr <= r_oldest;
                        case (t_opcode'(req.opcode))
                            OP_LOOKUP: r_state <= S_SCAN;
                            OP_INSERT: r_state <= S_INS_RD;
                            OP_TRIM:   r_state <= S_TRIM;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                // one tag read per cycle, compared in the cycle after it is issued
                S_SCAN: begin
                    r_pend <= scan_issue;
                    if (scan_issue) begin
                        r_idx <= r_idx + OW'(1);
                    end
                    if (r_pend && tag_match) begin
                        r_hit   <= 1'b1;
                        r_hits  <= r_hits + CounterW'(1);
                        r_state <= S_DONE;
                    end else if (!scan_issue && !r_pend) begin
                        r_misses <= r_misses + CounterW'(1);
                        r_state  <= S_DONE;
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_EV;
                end
                // drop the oldest entry when full
                S_INS_EV: begin
                    if (evict) begin
                        r_freed  <= TotalW'(i_bytes);
                        r_total  <= r_total - TotalW'(i_bytes);
                        r_oldest <= oldest_inc;
                        r_occ    <= r_occ - OW'(1);
                    end
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    r_occ   <= r_occ + OW'(1);
                    r_total <= r_total + TotalW'(r_eb);
                    r_state <= S_DONE;
                end
                // read ahead one slot a cycle; consume while over target
                S_TRIM: begin
                    r_rd_ptr <= ptr_inc;
                    if (r_pend && !trim_more) begin
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pend <= 1'b1;
                        if (r_pend) begin
                            r_total  <= r_total - TotalW'(i_bytes);
                            r_freed  <= r_freed + TotalW'(i_bytes);
                            r_oldest <= oldest_inc;
                            r_occ    <= r_occ - OW'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_hit     <= r_hit;
                        r_o_evicted <= r_freed;
                        r_o_count   <= CountOutW'(r_occ);
                        r_o_total   <= r_total;
                        r_o_hits    <= r_hits;
                        r_o_misses  <= r_misses;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/fifo_segment_cache.sv */
// fifo_segment_cache: top level of the FIFO-replacement segment descriptor cache.
// Depends on fsc_pkg, fsc_if, fsc_mem, fsc_engine and fifo_segment_cache_defines.svh.
//
// Channel   Dir  Handshake     Carries
// i_req     in   valid/ready   opcode, start_id, seg_count, entry_bytes, target_mb
// o_rsp     out  valid/ready   hit, evicted_bytes, entry_count, total_bytes, counters
// i_cfg     in   valid/ready   capacity (always ready)
//
// One request at a time. Lookup scans the stored entries in S_SCAN through the single
// tag-memory read port, one entry a cycle, and stops early on a hit. Insert steps through
// S_INS_RD, S_INS_EV and S_INS_WR. Trim: one byte-memory read a cycle in S_TRIM.
// Reset is synchronous; memories need no clearing pass. A held response does not
// block the next request, which waits only at its own response.
`include "fifo_segment_cache_defines.svh"

module fifo_segment_cache #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsc_cfg_if.sink   i_cfg,
    fsc_req_if.sink   i_req,
    fsc_rsp_if.source o_rsp
);
    import fsc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    logic [CapW-1:0]   r_capacity;
    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_wr_addr;
    logic [IdW-1:0]    w_wr_start;
    logic [IdW-1:0]    w_wr_count;
    logic [BytesW-1:0] w_wr_bytes;
    logic [AW-1:0]     w_tag_rd_addr;
    logic [AW-1:0]     w_byte_rd_addr;
    logic [IdW-1:0]    w_tag_start;
    logic [IdW-1:0]    w_tag_count;
    logic [BytesW-1:0] w_bytes;

    // capacity register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CapReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_capacity <= i_cfg.capacity;
        end
    end

    fsc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk          (i_clk),
        .i_ctl          (w_mem_ctl),
        .i_wr_addr      (w_wr_addr),
        .i_wr_start     (w_wr_start),
        .i_wr_count     (w_wr_count),
        .i_wr_bytes     (w_wr_bytes),
        .i_tag_rd_addr  (w_tag_rd_addr),
        .i_byte_rd_addr (w_byte_rd_addr),
        .o_tag_start    (w_tag_start),
        .o_tag_count    (w_tag_count),
        .o_bytes        (w_bytes)
    );

    fsc_engine #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .OW    (OW)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_capacity     (r_capacity),
        .req            (i_req),
        .rsp            (o_rsp),
        .o_mem_ctl      (w_mem_ctl),
        .o_wr_addr      (w_wr_addr),
        .o_wr_start     (w_wr_start),
        .o_wr_count     (w_wr_count),
        .o_wr_bytes     (w_wr_bytes),
        .o_tag_rd_addr  (w_tag_rd_addr),
        .o_byte_rd_addr (w_byte_rd_addr),
        .i_tag_start    (w_tag_start),
        .i_tag_count    (w_tag_count),
        .i_bytes        (w_bytes)
    );

    // a memory write never shares a cycle with a read
    `FSC_ASSERT_SAME(a_wr_no_rd, w_mem_ctl.wr_en,
        !w_mem_ctl.tag_rd_en && !w_mem_ctl.byte_rd_en, "memory write overlaps a read")
    // writes only happen while a request is in flight
    `FSC_ASSERT_SAME(a_wr_busy, w_mem_ctl.wr_en, !i_req.ready, "memory write while idle")
    // an accepted request closes the input until it completes
    `FSC_ASSERT_NEXT(a_one_req, i_req.valid && i_req.ready, !i_req.ready,
        "second request taken while busy")

endmodule
